/* sv/lorawan_adaptive_data_rate_defines.svh */
// Assertion macros for the adaptive data rate block.
`ifndef LORAWAN_ADAPTIVE_DATA_RATE_DEFINES_SVH
`define LORAWAN_ADAPTIVE_DATA_RATE_DEFINES_SVH
`ifndef SYNTHESIS
`define LADR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ladr assertion failed");
`define LADR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ladr assertion failed");
`else
`define LADR_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define LADR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* sv/ladr_pkg.sv */
// Shared types, constants and codes of the adaptive data rate block.
package ladr_pkg;

   localparam int HISTORY_DEPTH_DEF = 128;
   localparam int MAX_GATEWAYS_DEF  = 16;
   localparam int MIN_TX_POWER      = 2;
   localparam int MAX_TX_POWER      = 14;
   localparam int QDB_PER_STEP      = 12;

   localparam int PWR_W = 11;
   localparam int SNR_W = 12;
   localparam int RNG_W = 7;
   localparam int DIV_W = 20;
   localparam int DVS_W = 7;

   localparam logic [1:0] MODE_AVG = 2'd0;
   localparam logic [1:0] MODE_MAX = 2'd1;
   localparam logic [1:0] MODE_MIN = 2'd2;

   localparam logic [1:0] ST_ADR_OFF   = 2'd0;
   localparam logic [1:0] ST_SHORT     = 2'd1;
   localparam logic [1:0] ST_NO_CHANGE = 2'd2;
   localparam logic [1:0] ST_COMMAND   = 2'd3;

   localparam logic [2:0] REG_GW_MODE    = 3'd0;
   localparam logic [2:0] REG_HIST_MODE  = 3'd1;
   localparam logic [2:0] REG_HIST_RANGE = 3'd2;
   localparam logic [2:0] REG_PWR_ADJ    = 3'd3;
   localparam logic [2:0] REG_MARGIN     = 3'd4;
   localparam logic [2:0] REG_NOISE      = 3'd5;
   localparam logic [2:0] REG_THR_TABLE  = 3'd6;
   localparam logic [2:0] REG_MAX_DR     = 3'd7;

   typedef struct packed {
      logic                    start;
      logic signed [DIV_W-1:0] dividend;
      logic [DVS_W-1:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic                    busy;
      logic                    done;
      logic signed [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* sv/ladr_ram.sv */
// Generic single-port-write, registered-read RAM.
module ladr_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 128,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/ladr_div.sv */
// Shared bit-serial signed floor divider by a small positive divisor.
module ladr_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ladr_pkg::div_req_type div_req,
   output ladr_pkg::div_rsp_type div_rsp
);
   import ladr_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   trial;
   logic [DIV_W-1:0] mag;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      mag     = div_req.dividend[DIV_W-1] ? DIV_W'(-div_req.dividend) : div_req.dividend;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = mag;
         rem_in  = '0;
         neg_in  = div_req.dividend[DIV_W-1];
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   // floor for negative dividends: -q, or -q-1 when a remainder is left
   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = !neg_ff ? quo_ff : ((rem_ff != '0) ? ~quo_ff : -quo_ff);

endmodule

/* sv/lorawan_adaptive_data_rate.sv */
// Top level: per-device adaptive data rate sequencer with SNR history ring.
//
// Channel | Dir | Contents
// req     | in  | tdata: rx_power_qdb, adr_bit, current_data_rate, current_tx_power;
//         |     | tuser: req_type; tlast: last_gateway
// rsp     | out | tdata: reply_needed, new_data_rate, new_tx_power, tx_power_index;
//         |     | tuser: adr_status
// csr     | in  | write enable, register index, 64-bit write data
//
// Reception word: a closing one also passes S_CLOSE, and S_GDIV with averaging.
// ADR word: goes straight to S_FINISH without a history walk; otherwise S_WALK reads
// the history RAM (one history RAM read per cycle), then the shared divider runs a pass
// for the history average (S_HDIV, averaging only) and one for the steps (S_SDIV),
// with S_MARGIN before the steps and S_ADJUST and S_FINISH after them.
// req_tready is low while a word is in work. A result waits in the output register;
// a further ADR word stalls only when it has its own result ready to load.
// Reset is synchronous; the history RAM needs no clearing pass.
`include "lorawan_adaptive_data_rate_defines.svh"
module lorawan_adaptive_data_rate #(
   parameter int HISTORY_DEPTH = ladr_pkg::HISTORY_DEPTH_DEF,
   parameter int MAX_GATEWAYS  = ladr_pkg::MAX_GATEWAYS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [10:0] rx_power_qdb, [11] adr_bit, [14:12] current_data_rate,
   // [19:15] current_tx_power, [23:20] zero
   input  logic [23:0] req_tdata,
   // [0] req_type
   input  logic        req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] reply_needed, [3:1] new_data_rate, [8:4] new_tx_power,
   // [11:9] tx_power_index, [15:12] zero
   output logic [15:0] rsp_tdata,
   // [1:0] adr_status
   output logic [1:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata
);
   import ladr_pkg::*;

   localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int GCNT_W = $clog2(MAX_GATEWAYS + 1);
   localparam int GSUM_W = PWR_W + GCNT_W;
   localparam int HSUM_W = SNR_W + RNG_W;
   localparam int MRG_W  = SNR_W + 1;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CLOSE  = 4'd1;
   localparam logic [3:0] S_GDIV   = 4'd2;
   localparam logic [3:0] S_WALK   = 4'd3;
   localparam logic [3:0] S_HDIV   = 4'd4;
   localparam logic [3:0] S_MARGIN = 4'd5;
   localparam logic [3:0] S_SDIV   = 4'd6;
   localparam logic [3:0] S_ADJUST = 4'd7;
   localparam logic [3:0] S_FINISH = 4'd8;

   localparam logic [5:0] MIN6 = 6'(MIN_TX_POWER);
   localparam logic [5:0] MAX6 = 6'(MAX_TX_POWER);

   function automatic logic [2:0] power_index(input logic [4:0] p);
      logic [2:0] idx;
      if (p >= 5'd14)      idx = 3'd0;
      else if (p >= 5'd12) idx = 3'd1;
      else if (p >= 5'd10) idx = 3'd2;
      else if (p >= 5'd8)  idx = 3'd3;
      else if (p >= 5'd6)  idx = 3'd4;
      else if (p >= 5'd4)  idx = 3'd5;
      else if (p >= 5'd2)  idx = 3'd6;
      else                 idx = 3'd7;
      return idx;
   endfunction

   // configuration
   logic [1:0]              gmode_ff, hmode_ff;
   logic [RNG_W-1:0]        hrange_ff;
   logic                    pae_ff;
   logic signed [9:0]       dmargin_ff;
   logic signed [PWR_W-1:0] noise_ff;
   logic [63:0]             thr_tbl_ff;
   logic [2:0]              mdr_ff;

   // control
   logic [3:0]        state_ff, state_in;
   logic [GCNT_W-1:0] gcnt_ff, gcnt_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [7:0]        pcount_ff, pcount_in;
   logic [RNG_W-1:0]  issue_ff, issue_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              first_ff, first_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   logic signed [GSUM_W-1:0] gsum_ff, gsum_in;
   logic signed [PWR_W-1:0]  gmax_ff, gmax_in, gmin_ff, gmin_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [RNG_W-1:0]         range_ff, range_in;
   logic signed [HSUM_W-1:0] hsum_ff, hsum_in;
   logic signed [SNR_W-1:0]  hmax_ff, hmax_in, hmin_ff, hmin_in;
   logic signed [SNR_W-1:0]  snr_ff, snr_in;
   logic [2:0]               cur_dr_ff, cur_dr_in;
   logic [4:0]               cur_tx_ff, cur_tx_in;
   logic                     sneg_ff, sneg_in;
   logic [5:0]               smag_ff, smag_in;
   logic [1:0]               status_ff, status_in;
   logic [2:0]               res_dr_ff, res_dr_in;
   logic [4:0]               res_tx_ff, res_tx_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic [2:0]               rsp_dr_ff, rsp_dr_in;
   logic [4:0]               rsp_tx_ff, rsp_tx_in;

   // combinational
   logic                     req_acc;
   logic signed [PWR_W-1:0]  rx_pwr;
   logic [RNG_W-1:0]         rng;
   logic signed [PWR_W-1:0]  pw_sel;
   logic signed [SNR_W-1:0]  snr_wr;
   logic signed [SNR_W-1:0]  hval;
   logic signed [7:0]        thr;
   logic signed [MRG_W-1:0]  margin;
   logic [DIV_W-1:0]         absq;
   logic [2:0]               dr_room, up;
   logic [5:0]               rem;
   logic [5:0]               dn_room, up_room;
   logic [5:0]               dn, kup;
   logic [5:0]               tx_dn, tx_sum, tx_up;
   logic [4:0]               tx_new;
   logic [2:0]               dr_new;
   logic                     ram_we;
   logic [SNR_W-1:0]         ram_rdata;
   div_req_type              div_req;
   div_rsp_type              div_rsp;

   assign req_acc    = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rx_pwr     = req_tdata[10:0];

   always_comb begin
      if (hrange_ff == '0) begin
         rng = RNG_W'(1);
      end else if (32'(hrange_ff) > HISTORY_DEPTH) begin
         rng = RNG_W'(HISTORY_DEPTH);
      end else begin
         rng = hrange_ff;
      end
   end

   assign pw_sel = (state_ff == S_GDIV) ? div_rsp.quotient[PWR_W-1:0] :
                   ((gmode_ff == MODE_MIN) ? gmin_ff : gmax_ff);
   assign snr_wr = SNR_W'(pw_sel) - SNR_W'(noise_ff);
   assign hval   = ram_rdata;
   assign thr    = thr_tbl_ff[{cur_dr_ff, 3'b000} +: 8];
   assign margin = MRG_W'(snr_ff) - MRG_W'(thr) - MRG_W'(dmargin_ff);
   assign absq   = div_rsp.quotient[DIV_W-1] ? DIV_W'(-div_rsp.quotient) : div_rsp.quotient;

   // step application: rate first, then 2 dB power steps; negative steps only raise power
   always_comb begin
      dr_room = (cur_dr_ff < mdr_ff) ? mdr_ff - cur_dr_ff : 3'd0;
      up      = (smag_ff < {3'b000, dr_room}) ? smag_ff[2:0] : dr_room;
      rem     = smag_ff - {3'b000, up};
      dn_room = ({1'b0, cur_tx_ff} > MIN6) ? ({1'b0, cur_tx_ff} - MIN6 + 6'd1) >> 1 : 6'd0;
      dn      = (rem < dn_room) ? rem : dn_room;
      tx_dn   = ({dn[4:0], 1'b0} > {1'b0, cur_tx_ff}) ? 6'd0 :
                {1'b0, cur_tx_ff} - {dn[4:0], 1'b0};
      up_room = ({1'b0, cur_tx_ff} < MAX6) ? (MAX6 - {1'b0, cur_tx_ff} + 6'd1) >> 1 : 6'd0;
      kup     = (smag_ff < up_room) ? smag_ff : up_room;
      tx_sum  = {1'b0, cur_tx_ff} + {kup[4:0], 1'b0};
      tx_up   = (tx_sum > 6'd31) ? 6'd31 : tx_sum;
      if (!sneg_ff && smag_ff != '0) begin
         dr_new = cur_dr_ff + up;
         tx_new = tx_dn[4:0];
      end else if (sneg_ff) begin
         dr_new = cur_dr_ff;
         tx_new = tx_up[4:0];
      end else begin
         dr_new = cur_dr_ff;
         tx_new = cur_tx_ff;
      end
      if (!pae_ff) begin
         tx_new = cur_tx_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      gcnt_in       = gcnt_ff;
      wp_in         = wp_ff;
      pcount_in     = pcount_ff;
      issue_in      = issue_ff;
      rd_pend_in    = 1'b0;
      first_in      = first_ff;
      gsum_in       = gsum_ff;
      gmax_in       = gmax_ff;
      gmin_in       = gmin_ff;
      rd_ptr_in     = rd_ptr_ff;
      range_in      = range_ff;
      hsum_in       = hsum_ff;
      hmax_in       = hmax_ff;
      hmin_in       = hmin_ff;
      snr_in        = snr_ff;
      cur_dr_in     = cur_dr_ff;
      cur_tx_in     = cur_tx_ff;
      sneg_in       = sneg_ff;
      smag_in       = smag_ff;
      status_in     = status_ff;
      res_dr_in     = res_dr_ff;
      res_tx_in     = res_tx_ff;
      rsp_status_in = rsp_status_ff;
      rsp_dr_in     = rsp_dr_ff;
      rsp_tx_in     = rsp_tx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      ram_we        = 1'b0;
      div_req       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc && !req_tuser) begin
               if (32'(gcnt_ff) < MAX_GATEWAYS) begin
                  if (gcnt_ff == '0) begin
                     gmax_in = rx_pwr;
                     gmin_in = rx_pwr;
                  end else begin
                     if (rx_pwr > gmax_ff) gmax_in = rx_pwr;
                     if (rx_pwr < gmin_ff) gmin_in = rx_pwr;
                  end
                  gsum_in = gsum_ff + GSUM_W'(rx_pwr);
                  gcnt_in = gcnt_ff + 1'b1;
               end
               if (req_tlast) begin
                  state_in = S_CLOSE;
               end
            end else if (req_acc) begin
               cur_dr_in = req_tdata[14:12];
               cur_tx_in = req_tdata[19:15];
               res_dr_in = req_tdata[14:12];
               res_tx_in = req_tdata[19:15];
               range_in  = rng;
               issue_in  = '0;
               first_in  = 1'b1;
               rd_ptr_in = (wp_ff == '0) ? PTR_W'(HISTORY_DEPTH - 1) : wp_ff - 1'b1;
               if (!req_tdata[11]) begin
                  status_in = ST_ADR_OFF;
                  state_in  = S_FINISH;
               end else if (pcount_ff < {1'b0, rng}) begin
                  status_in = ST_SHORT;
                  state_in  = S_FINISH;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_CLOSE, S_GDIV: begin
            if (state_ff == S_CLOSE && gmode_ff == MODE_AVG) begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_W'(gsum_ff);
               div_req.divisor  = DVS_W'(gcnt_ff);
               state_in         = S_GDIV;
            end else if (state_ff == S_CLOSE || div_rsp.done) begin
               ram_we    = 1'b1;
               wp_in     = (32'(wp_ff) == HISTORY_DEPTH - 1) ? '0 : wp_ff + 1'b1;
               pcount_in = (pcount_ff == 8'hFF) ? pcount_ff : pcount_ff + 1'b1;
               gsum_in   = '0;
               gmax_in   = '0;
               gmin_in   = '0;
               gcnt_in   = '0;
               state_in  = S_IDLE;
            end
         end
         S_WALK: begin
            if (issue_ff < range_ff) begin
               issue_in   = issue_ff + 1'b1;
               rd_pend_in = 1'b1;
               rd_ptr_in  = (rd_ptr_ff == '0) ? PTR_W'(HISTORY_DEPTH - 1) : rd_ptr_ff - 1'b1;
            end
            if (rd_pend_ff) begin
               first_in = 1'b0;
               if (first_ff) begin
                  hsum_in = HSUM_W'(hval);
                  hmax_in = hval;
                  hmin_in = hval;
               end else begin
                  hsum_in = hsum_ff + HSUM_W'(hval);
                  if (hval > hmax_ff) hmax_in = hval;
                  if (hval < hmin_ff) hmin_in = hval;
               end
            end else if (issue_ff == range_ff) begin
               if (hmode_ff == MODE_AVG) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = DIV_W'(hsum_ff);
                  div_req.divisor  = DVS_W'(range_ff);
                  state_in         = S_HDIV;
               end else begin
                  snr_in   = (hmode_ff == MODE_MIN) ? hmin_ff : hmax_ff;
                  state_in = S_MARGIN;
               end
            end
         end
         S_HDIV: begin
            if (div_rsp.done) begin
               snr_in   = div_rsp.quotient[SNR_W-1:0];
               state_in = S_MARGIN;
            end
         end
         S_MARGIN: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(margin);
            div_req.divisor  = DVS_W'(QDB_PER_STEP);
            state_in         = S_SDIV;
         end
         S_SDIV: begin
            if (div_rsp.done) begin
               sneg_in  = div_rsp.quotient[DIV_W-1];
               smag_in  = (absq > DIV_W'(63)) ? 6'd63 : absq[5:0];
               state_in = S_ADJUST;
            end
         end
         S_ADJUST: begin
            res_dr_in = dr_new;
            res_tx_in = tx_new;
            status_in = (dr_new != cur_dr_ff || tx_new != cur_tx_ff) ? ST_COMMAND : ST_NO_CHANGE;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_dr_in     = res_dr_ff;
               rsp_tx_in     = res_tx_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gmode_ff   <= MODE_MAX;
         hmode_ff   <= MODE_MAX;
         hrange_ff  <= RNG_W'(20);
         pae_ff     <= 1'b1;
         dmargin_ff <= '0;
         noise_ff   <= -11'sd468;
         thr_tbl_ff <= '0;
         mdr_ff     <= 3'd5;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_GW_MODE:    gmode_ff   <= csr_wdata[1:0];
            REG_HIST_MODE:  hmode_ff   <= csr_wdata[1:0];
            REG_HIST_RANGE: hrange_ff  <= csr_wdata[RNG_W-1:0];
            REG_PWR_ADJ:    pae_ff     <= csr_wdata[0];
            REG_MARGIN:     dmargin_ff <= csr_wdata[9:0];
            REG_NOISE:      noise_ff   <= csr_wdata[PWR_W-1:0];
            REG_THR_TABLE:  thr_tbl_ff <= csr_wdata;
            REG_MAX_DR:     mdr_ff     <= csr_wdata[2:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gcnt_ff      <= '0;
         wp_ff        <= '0;
         pcount_ff    <= '0;
         issue_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gsum_ff      <= '0;
         gmax_ff      <= '0;
         gmin_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         gcnt_ff      <= gcnt_in;
         wp_ff        <= wp_in;
         pcount_ff    <= pcount_in;
         issue_ff     <= issue_in;
         rd_pend_ff   <= rd_pend_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         gsum_ff      <= gsum_in;
         gmax_ff      <= gmax_in;
         gmin_ff      <= gmin_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      range_ff      <= range_in;
      hsum_ff       <= hsum_in;
      hmax_ff       <= hmax_in;
      hmin_ff       <= hmin_in;
      snr_ff        <= snr_in;
      cur_dr_ff     <= cur_dr_in;
      cur_tx_ff     <= cur_tx_in;
      sneg_ff       <= sneg_in;
      smag_ff       <= smag_in;
      status_ff     <= status_in;
      res_dr_ff     <= res_dr_in;
      res_tx_ff     <= res_tx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_dr_ff     <= rsp_dr_in;
      rsp_tx_ff     <= rsp_tx_in;
   end

   ladr_ram #(
      .WIDTH (SNR_W),
      .DEPTH (HISTORY_DEPTH),
      .AW    (PTR_W)
   ) u_hist_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (wp_ff),
      .wdata (snr_wr),
      .raddr (rd_ptr_ff),
      .rdata (ram_rdata)
   );

   ladr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'b0000, power_index(rsp_tx_ff), rsp_tx_ff, rsp_dr_ff,
                        (rsp_status_ff == ST_COMMAND)};

   `LADR_ASSERT_IMPL(a_div_free, clock, reset, div_req.start, !div_rsp.busy)
   `LADR_ASSERT_IMPL(a_walk_bound, clock, reset, state_ff == S_WALK, issue_ff <= range_ff)
   `LADR_ASSERT_NEXT(a_busy_after_adr, clock, reset, req_acc && req_tuser, !req_tready)
   `LADR_ASSERT_IMPL(a_gw_bound, clock, reset, 1'b1, 32'(gcnt_ff) <= MAX_GATEWAYS)

endmodule

/* tb/tb_lorawan_adaptive_data_rate.sv */
// Self-checking testbench for the adaptive data rate block: tracks expected ADR replies per word.
module tb_lorawan_adaptive_data_rate;
   import ladr_pkg::*;

   localparam logic KIND_RX  = 1'b0;
   localparam logic KIND_ADR = 1'b1;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int PHASE_WORDS   = 200;

   typedef struct packed {
      logic              kind;
      logic signed [10:0] power;
      logic              last;
      logic              adr;
      logic [2:0]        dr;
      logic [4:0]        tx;
   } uplink_word_type;

   typedef struct packed {
      logic [1:0] status;
      logic       reply;
      logic [2:0] dr;
      logic [4:0] tx;
      logic [2:0] pidx;
   } adr_reply_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [63:0] csr_wdata;

   // predictor configuration
   logic [1:0]         gw_mode;
   logic [1:0]         hist_mode;
   logic [6:0]         hist_range;
   logic               pwr_adj;
   logic signed [9:0]  margin_cfg;
   logic signed [10:0] noise_cfg;
   logic [63:0]        thr_table;
   logic [2:0]         max_dr;

   // predictor state
   int                 gw_sum, gw_max, gw_min, gw_cnt;
   logic signed [11:0] snr_ring [HISTORY_DEPTH_DEF];
   int                 wr_ptr, pkt_count;

   adr_reply_type adr_expect_q[$];
   adr_reply_type exp_reply;
   int         mismatch_count = 0;
   int         cycle_count = 0;
   int         rsp_hold_cycles = 0;
   int         rsp_style = 0;
   int         burst_left = 0;
   bit         sender_gaps = 0;

   lorawan_adaptive_data_rate u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver: long hold-off when requested, else always ready or its own stall pattern
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
      if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         case (rsp_style)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 9) < 7);
            default: rsp_tready <= ((cycle_count % 13) < 8);
         endcase
      end
   end

   function automatic void note_mismatch(string what, logic [7:0] exp, logic [7:0] act);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %s: expected %0d, got %0d", what, exp, act);
   endfunction

   function automatic void check_field(string what, logic [7:0] exp, logic [7:0] act);
      if (act !== exp)
         note_mismatch(what, exp, act);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (adr_expect_q.size() == 0) begin
            note_mismatch("reply with nothing pending", 0, rsp_tuser);
         end else begin
            exp_reply = adr_expect_q.pop_front();
            check_field("adr_status", exp_reply.status, rsp_tuser);
            check_field("reply_needed", exp_reply.reply, rsp_tdata[0]);
            check_field("new_data_rate", exp_reply.dr, rsp_tdata[3:1]);
            check_field("new_tx_power", exp_reply.tx, rsp_tdata[8:4]);
            check_field("tx_power_index", exp_reply.pidx, rsp_tdata[11:9]);
         end
      end
   end

   function automatic int floor_div(int a, int b);
      int q;
      q = a / b;
      if ((a % b != 0) && ((a < 0) != (b < 0)))
         q--;
      return q;
   endfunction

   function automatic logic [2:0] tx_index(int p);
      if (p >= 14)
         return 3'd0;
      if (p < 2)
         return 3'd7;
      return 3'(7 - p / 2);
   endfunction

   function automatic void model_reset();
      gw_mode = MODE_MAX;
      hist_mode = MODE_MAX;
      hist_range = 7'd20;
      pwr_adj = 1'b1;
      margin_cfg = '0;
      noise_cfg = -11'sd468;
      thr_table = '0;
      max_dr = 3'd5;
      gw_sum = 0;
      gw_max = 0;
      gw_min = 0;
      gw_cnt = 0;
      wr_ptr = 0;
      pkt_count = 0;
   endfunction

   function automatic void apply_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
         REG_GW_MODE:    gw_mode = v[1:0];
         REG_HIST_MODE:  hist_mode = v[1:0];
         REG_HIST_RANGE: hist_range = v[6:0];
         REG_PWR_ADJ:    pwr_adj = v[0];
         REG_MARGIN:     margin_cfg = v[9:0];
         REG_NOISE:      noise_cfg = v[10:0];
         REG_THR_TABLE:  thr_table = v;
         REG_MAX_DR:     max_dr = v[2:0];
         default: ;
      endcase
   endfunction

   // update state for one accepted word; ADR words queue their expected reply
   function automatic void predict_word(uplink_word_type w);
      int p, pw, rng, sum, mx, mn, snr, margin, steps, thr, dr, tx, i, v;
      adr_reply_type r;
      if (w.kind == KIND_RX) begin
         if (gw_cnt < MAX_GATEWAYS_DEF) begin
            p = int'($signed(w.power));
            if (gw_cnt == 0) begin
               gw_max = p;
               gw_min = p;
            end else begin
               if (p > gw_max) gw_max = p;
               if (p < gw_min) gw_min = p;
            end
            gw_sum += p;
            gw_cnt++;
         end
         if (w.last) begin
            case (gw_mode)
               MODE_AVG: pw = floor_div(gw_sum, gw_cnt);
               MODE_MIN: pw = gw_min;
               default:  pw = gw_max;
            endcase
            snr_ring[wr_ptr] = 12'(pw - int'(noise_cfg));
            wr_ptr = (wr_ptr + 1) % HISTORY_DEPTH_DEF;
            if (pkt_count < 255)
               pkt_count++;
            gw_sum = 0;
            gw_max = 0;
            gw_min = 0;
            gw_cnt = 0;
         end
         return;
      end
      dr = w.dr;
      tx = w.tx;
      if (!w.adr) begin
         r.status = ST_ADR_OFF;
      end else begin
         rng = (hist_range == 0) ? 1 : int'(hist_range);
         if (rng > HISTORY_DEPTH_DEF)
            rng = HISTORY_DEPTH_DEF;
         if (pkt_count < rng) begin
            r.status = ST_SHORT;
         end else begin
            sum = 0;
            mx = 0;
            mn = 0;
            for (i = 0; i < rng; i++) begin
               v = int'(snr_ring[(wr_ptr + HISTORY_DEPTH_DEF - 1 - i) % HISTORY_DEPTH_DEF]);
               if (i == 0) begin
                  mx = v;
                  mn = v;
               end
               if (v > mx) mx = v;
               if (v < mn) mn = v;
               sum += v;
            end
            case (hist_mode)
               MODE_AVG: snr = floor_div(sum, rng);
               MODE_MIN: snr = mn;
               default:  snr = mx;
            endcase
            thr = int'($signed(thr_table[8*w.dr +: 8]));
            margin = snr - thr - int'(margin_cfg);
            steps = floor_div(margin, QDB_PER_STEP);
            while (steps > 0 && dr < int'(max_dr)) begin
               dr++;
               steps--;
            end
            while (steps > 0 && tx > MIN_TX_POWER) begin
               tx -= 2;
               if (tx < 0) tx = 0;
               steps--;
            end
            while (steps < 0 && tx < MAX_TX_POWER) begin
               tx += 2;
               if (tx > 31) tx = 31;
               steps++;
            end
            if (!pwr_adj)
               tx = w.tx;
            r.status = (dr != int'(w.dr) || tx != int'(w.tx)) ? ST_COMMAND : ST_NO_CHANGE;
         end
      end
      r.reply = (r.status == ST_COMMAND);
      r.dr = dr[2:0];
      r.tx = tx[4:0];
      r.pidx = tx_index(tx);
      adr_expect_q.push_back(r);
   endfunction

   function automatic uplink_word_type make_word(logic kind, int power, logic last, logic adr,
                                                 int dr, int tx);
      uplink_word_type w;
      w.kind = kind;
      w.power = power[10:0];
      w.last = last;
      w.adr = adr;
      w.dr = dr[2:0];
      w.tx = tx[4:0];
      return w;
   endfunction

   function automatic int pick_power();
      int v;
      if ($urandom_range(0, 9) == 0)
         v = int'($urandom_range(0, 2047)) - 1024;
      else
         v = int'(noise_cfg) + int'($urandom_range(0, 320)) - 100;
      if (v > 1023) v = 1023;
      if (v < -1024) v = -1024;
      return v;
   endfunction

   function automatic uplink_word_type rx_word(logic last);
      return make_word(KIND_RX, pick_power(), last, 1'($urandom),
                       $urandom_range(0, 7), $urandom_range(0, 31));
   endfunction

   function automatic uplink_word_type adr_word(logic adr);
      int tx;
      tx = $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, 16);
      return make_word(KIND_ADR, int'($urandom_range(0, 2047)) - 1024, 1'($urandom), adr,
                       $urandom_range(0, 7), tx);
   endfunction

   task automatic send_word(input uplink_word_type w);
      req_tvalid <= 1'b1;
      req_tuser <= w.kind;
      req_tlast <= w.last;
      req_tdata <= {4'b0, w.tx, w.dr, w.adr, w.power};
      do @(posedge clock); while (!req_tready);
      predict_word(w);
   endtask

   task automatic send_paced(input uplink_word_type w);
      if (sender_gaps && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0)
         burst_left--;
      send_word(w);
   endtask

   task automatic wait_drain(input bit settle);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (adr_expect_q.size() != 0);
      if (settle)
         repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input int gw, input int hm, input int rng, input int adj,
                            input int margin, input int noise, input logic [63:0] thr_bits,
                            input int mdr);
      logic [63:0] vals [8];
      int idx;
      vals[REG_GW_MODE]    = 64'(gw & 3);
      vals[REG_HIST_MODE]  = 64'(hm & 3);
      vals[REG_HIST_RANGE] = 64'(rng & 'h7F);
      vals[REG_PWR_ADJ]    = 64'(adj & 1);
      vals[REG_MARGIN]     = 64'(margin & 'h3FF);
      vals[REG_NOISE]      = 64'(noise & 'h7FF);
      vals[REG_THR_TABLE]  = thr_bits;
      vals[REG_MAX_DR]     = 64'(mdr & 7);
      for (idx = 0; idx < 8; idx++) begin
         csr_we <= 1'b1;
         csr_addr <= idx[2:0];
         csr_wdata <= vals[idx];
         @(posedge clock);
         apply_reg(idx[2:0], vals[idx]);
      end
      csr_we <= 1'b0;
   endtask

   // ADR bit clear, short history, gateway overflow, range zero, rate above max
   task automatic test_corner_words();
      int j;
      send_word(make_word(KIND_ADR, -1024, 1'b1, 1'b0, 7, 31));
      send_word(make_word(KIND_ADR, 1023, 1'b0, 1'b1, 0, 0));
      for (j = 0; j < 17; j++) begin
         if (j == 0)
            send_word(make_word(KIND_RX, 1023, 1'b0, 1'b1, 7, 31));
         else if (j == 16)
            send_word(make_word(KIND_RX, -1024, 1'b1, 1'b0, 0, 0));
         else
            send_word(rx_word(1'b0));
      end
      wait_drain(1'b1);
      configure(MODE_MAX, MODE_MAX, 0, 1, 0, -468, {$urandom, $urandom}, 5);
      send_word(make_word(KIND_ADR, 0, 1'b0, 1'b1, 7, 31));
      send_word(make_word(KIND_ADR, 0, 1'b0, 1'b1, 0, 0));
      send_word(make_word(KIND_ADR, 0, 1'b0, 1'b1, 3, 14));
      wait_drain(1'b1);
      configure(MODE_AVG, MODE_MIN, 1, 0, 511, 1023, 64'h8080808080808080, 7);
      send_word(make_word(KIND_ADR, 0, 1'b0, 1'b1, 2, 1));
      wait_drain(1'b1);
   endtask

   // receiver holds off while ADR words keep coming, so the input stalls
   task automatic test_output_backpressure();
      int j;
      rsp_style = 0;
      sender_gaps = 0;
      configure(MODE_AVG, MODE_AVG, 2, 1, 0, -468, {$urandom, $urandom}, 5);
      rsp_hold_cycles = 400;
      send_word(rx_word(1'b1));
      send_word(rx_word(1'b1));
      for (j = 0; j < 10; j++)
         send_word(adr_word(1'b1));
      wait_drain(1'b1);
   endtask

   task automatic run_traffic(input int n_words);
      int sent, k, j, pick;
      sent = 0;
      while (sent < n_words) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            k = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            for (j = 0; j < k; j++)
               send_paced(rx_word(j == k - 1));
            sent += k;
         end else if (pick < 90) begin
            send_paced(adr_word($urandom_range(0, 9) != 0));
            sent++;
         end else if (pick < 97) begin
            send_paced(rx_word(1'($urandom)));
            sent++;
         end else begin
            wait_drain(1'b0);
         end
      end
   endtask

   task automatic test_random_settings();
      int p;
      for (p = 0; p < 9; p++) begin
         wait_drain(1'b1);
         case (p)
            0: configure(MODE_AVG, MODE_AVG, 4, 1, 0, -468, {$urandom, $urandom}, 5);
            1: configure(MODE_MAX, MODE_MIN, 1, 0, 511, -1024, 64'h8080808080808080, 7);
            2: configure(MODE_MIN, MODE_MAX, 0, 1, -512, 1023, 64'h7F7F7F7F7F7F7F7F, 0);
            3: configure(MODE_SPARE, MODE_SPARE, 8, 1, int'($urandom_range(0, 120)) - 60,
                         int'($urandom_range(0, 2047)) - 1024, 64'hFFFFFFFFFFFFFFFF, 3);
            4: configure(MODE_AVG, MODE_AVG, 100, 1, int'($urandom_range(0, 120)) - 60,
                         -468, {$urandom, $urandom}, $urandom_range(0, 7));
            5: configure(MODE_AVG, MODE_MAX, 127, 1, int'($urandom_range(0, 120)) - 60,
                         int'($urandom_range(0, 600)) - 700, {$urandom, $urandom}, 6);
            default: configure($urandom_range(0, 3), $urandom_range(0, 3),
                               $urandom_range(1, 16), $urandom_range(0, 1),
                               int'($urandom_range(0, 120)) - 60,
                               int'($urandom_range(0, 2047)) - 1024,
                               {$urandom, $urandom}, $urandom_range(0, 7));
         endcase
         rsp_style = p % 3;
         sender_gaps = (p % 4 != 3);
         burst_left = 0;
         run_traffic(PHASE_WORDS);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_RX;
      req_tlast = 1'b0;
      csr_we = 1'b0;
      csr_addr = REG_GW_MODE;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      model_reset();
      @(posedge clock);
      test_corner_words();
      test_output_backpressure();
      test_random_settings();
      wait_drain(1'b1);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* lorawan_adaptive_data_rate.f */
+incdir+sv
sv/ladr_pkg.sv
sv/ladr_ram.sv
sv/ladr_div.sv
sv/lorawan_adaptive_data_rate.sv
tb/tb_lorawan_adaptive_data_rate.sv
